// ----- design/dpc_pkg.sv -----
// dpc_pkg: shared types, widths and register map of the distance pid controller
// used by the request interfaces and by distance_pid_controller_unit
package dpc_pkg;

	localparam int unsigned DIST_W  = 31;
	localparam int unsigned GAIN_W  = 24;
	localparam int unsigned LIMIT_W = 31;
	localparam int unsigned CEIL_W  = 30;
	localparam int unsigned ERR_W   = 32;
	localparam int unsigned DIFF_W  = 33;
	localparam int unsigned DRIVE_W = 18;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;

	localparam int unsigned PTERM_W = GAIN_W + ERR_W - FRAC_W;
	localparam int unsigned DTERM_W = GAIN_W + DIFF_W - FRAC_W;
	localparam int unsigned SUM_W   = DTERM_W + 2;

	localparam logic signed [SUM_W-1:0] ONE_Q16 = SUM_W'(65536);

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST      = GAIN_W'(26214);
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST     = GAIN_W'(0);
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST     = GAIN_W'(720896);
	localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = LIMIT_W'(2147483647);
	localparam logic [CEIL_W-1:0]  ERROR_CEILING_RST  = CEIL_W'(196608);

	typedef enum logic [2:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_ERROR_CEILING  = 3'd4
	} reg_idx_t;

	typedef logic signed [DIST_W-1:0]  dist_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

endpackage

// ----- design/dpc_sample_if.sv -----
// dpc_sample_if: valid/ready channel for one controller sample request
// depends on dpc_pkg
interface dpc_sample_if import dpc_pkg::*; ();
	logic  valid;
	logic  ready;
	dist_t goal_distance;
	dist_t distance_traveled;
	logic  restart;

	modport source (output valid, goal_distance, distance_traveled, restart, input ready);
	modport sink (input valid, goal_distance, distance_traveled, restart, output ready);
endinterface

// ----- design/dpc_result_if.sv -----
// dpc_result_if: valid/ready channel for one controller result request
// depends on dpc_pkg
interface dpc_result_if import dpc_pkg::*; ();
	logic   valid;
	logic   ready;
	drive_t drive_value;
	diff_t  diff_error;

	modport source (output valid, drive_value, diff_error, input ready);
	modport sink (input valid, drive_value, diff_error, output ready);
endinterface

// ----- design/distance_pid_controller_unit.sv -----
// distance_pid_controller_unit: pid controller with integral clamp, apb configuration
// depends on dpc_pkg, dpc_sample_if, dpc_result_if
// path: input, error/integral, product and output registers; the error/integral
// update is one registered stage; one request per cycle unless result.ready stalls
// stages: input register, error and integral, three gain multipliers, sum and clamp
// reset: arst_n clears valids, previous error, integral and loads register defaults
module distance_pid_controller_unit import dpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dpc_sample_if.sink        sample,
	dpc_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [LIMIT_W-1:0] integral_limit_q;
	logic [CEIL_W-1:0]  error_ceiling_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= PROP_GAIN_RST;
			integ_gain_q     <= INTEG_GAIN_RST;
			deriv_gain_q     <= DERIV_GAIN_RST;
			integral_limit_q <= INTEGRAL_LIMIT_RST;
			error_ceiling_q  <= ERROR_CEILING_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PROP_GAIN:      prop_gain_q      <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:     integ_gain_q     <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:     deriv_gain_q     <= pwdata[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= pwdata[LIMIT_W-1:0];
				REG_ERROR_CEILING:  error_ceiling_q  <= pwdata[CEIL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PROP_GAIN:      prdata = DATA_W'(prop_gain_q);
			REG_INTEG_GAIN:     prdata = DATA_W'(integ_gain_q);
			REG_DERIV_GAIN:     prdata = DATA_W'(deriv_gain_q);
			REG_INTEGRAL_LIMIT: prdata = DATA_W'(integral_limit_q);
			REG_ERROR_CEILING:  prdata = DATA_W'(error_ceiling_q);
			default:            prdata = '0;
		endcase
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3, v_out_q;
	logic adv_s1, adv_s2, adv_s3, adv_out;

	assign adv_out      = !v_out_q || result.ready;
	assign adv_s3       = !v_s3 || adv_out;
	assign adv_s2       = !v_s2 || adv_s3;
	assign adv_s1       = !v_s1 || adv_s2;
	assign sample.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (adv_s1)  v_s1    <= sample.valid;
			if (adv_s2)  v_s2    <= v_s1;
			if (adv_s3)  v_s3    <= v_s2;
			if (adv_out) v_out_q <= v_s3;
		end
	end

	// input register
	dist_t goal_s1, trav_s1;
	logic  restart_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			goal_s1    <= sample.goal_distance;
			trav_s1    <= sample.distance_traveled;
			restart_s1 <= sample.restart;
		end
	end

	// error, difference and integral
	logic signed [ERR_W-1:0]  prev_err_q, integ_q;
	logic signed [ERR_W:0]    err_raw, ceil_x, err_cap;
	logic signed [ERR_W-1:0]  err, integ_base, sum_clamped;
	logic signed [ERR_W+1:0]  sum_x, lim_x, diff_x, mag_x;
	logic signed [DIFF_W-1:0] diff_z;

	always_comb begin
		err_raw = (ERR_W+1)'(goal_s1) - (ERR_W+1)'(trav_s1);
		ceil_x  = $signed({{(ERR_W+1-CEIL_W){1'b0}}, error_ceiling_q});
		err_cap = (err_raw > ceil_x) ? ceil_x : err_raw;
		err     = err_cap[ERR_W-1:0];

		integ_base = restart_s1 ? '0 : integ_q;
		sum_x      = (ERR_W+2)'(integ_base) + (ERR_W+2)'(err);
		lim_x      = $signed({{(ERR_W+2-LIMIT_W){1'b0}}, integral_limit_q});
		if (sum_x > lim_x)
			sum_x = lim_x;
		if (sum_x < -lim_x)
			sum_x = -lim_x;
		sum_clamped = sum_x[ERR_W-1:0];

		diff_x = (ERR_W+2)'(err) - (ERR_W+2)'(prev_err_q);
		mag_x  = (err < 0) ? -(ERR_W+2)'(err) : (ERR_W+2)'(err);
		diff_z = (diff_x >= mag_x) ? '0 : diff_x[DIFF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (v_s1 && adv_s2) begin
			prev_err_q <= err;
			integ_q    <= sum_clamped;
		end
	end

	logic signed [ERR_W-1:0]  err_s2, sum_s2;
	logic signed [DIFF_W-1:0] diff_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			err_s2  <= err;
			sum_s2  <= sum_clamped;
			diff_s2 <= diff_z;
		end
	end

	// gain multipliers, floor shift by the fraction width
	logic signed [GAIN_W+ERR_W-1:0]  p_prod, i_prod;
	logic signed [GAIN_W+DIFF_W-1:0] d_prod;
	logic signed [PTERM_W-1:0]       pt_s3, it_s3;
	logic signed [DTERM_W-1:0]       dt_s3;

	assign p_prod = $signed(prop_gain_q) * err_s2;
	assign i_prod = $signed(integ_gain_q) * sum_s2;
	assign d_prod = $signed(deriv_gain_q) * diff_s2;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			pt_s3 <= p_prod[GAIN_W+ERR_W-1:FRAC_W];
			it_s3 <= i_prod[GAIN_W+ERR_W-1:FRAC_W];
			dt_s3 <= d_prod[GAIN_W+DIFF_W-1:FRAC_W];
		end
	end

	logic signed [DIFF_W-1:0] diff_s3;

	always_ff @(posedge clk) begin
		if (adv_s3)
			diff_s3 <= diff_s2;
	end

	// sum of terms and drive clamp
	logic signed [SUM_W-1:0] drive_sum;
	drive_t                  drive_clamped;

	always_comb begin
		drive_sum = SUM_W'(pt_s3) + SUM_W'(it_s3) + SUM_W'(dt_s3);
		if (drive_sum > ONE_Q16)
			drive_sum = ONE_Q16;
		if (drive_sum < -ONE_Q16)
			drive_sum = -ONE_Q16;
		drive_clamped = drive_sum[DRIVE_W-1:0];
	end

	drive_t drive_q;
	diff_t  diff_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			drive_q <= drive_clamped;
			diff_q  <= diff_s3;
		end
	end

	assign result.valid       = v_out_q;
	assign result.drive_value = drive_q;
	assign result.diff_error  = diff_q;

endmodule

// ----- test/tb_distance_pid_controller_unit.sv -----
// tb_distance_pid_controller_unit: self-checking bench for distance_pid_controller_unit,
// a directed table then phased random samples, each checked against a local pid model or
// a table literal; depends on dpc_pkg, dpc_sample_if, dpc_result_if and the unit itself
module tb_distance_pid_controller_unit;
	import dpc_pkg::*;

	localparam int unsigned NUM_REGS        = 5;
	localparam int unsigned N_DIR           = 28;
	localparam int unsigned NUM_PHASES      = 6;
	localparam int unsigned ITEMS_PER_PHASE = 284;
	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned MAX_REPORTS     = 10;
	localparam longint      DIST_MAX        = 1073741823;
	localparam longint      DIST_MIN        = -1073741824;
	localparam longint      DRIVE_MAX       = longint'(1) << FRAC_W;
	localparam logic [2:0]  IDX_UNUSED_LO   = 3'd5;
	localparam logic [2:0]  IDX_UNUSED_HI   = 3'd7;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [2:0]        idx;
		logic [DATA_W-1:0] data;
		dist_t             goal;
		dist_t             trav;
		logic              rst;
		logic              lit;
		drive_t            lit_drive;
		diff_t             lit_diff;
	} row_t;

	typedef struct packed {
		drive_t drive;
		diff_t  diff;
	} ctl_out_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	dpc_sample_if sample ();
	dpc_result_if result ();

	distance_pid_controller_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [GAIN_W-1:0]  kp_reg;
	logic [GAIN_W-1:0]  ki_reg;
	logic [GAIN_W-1:0]  kd_reg;
	logic [LIMIT_W-1:0] lim_reg;
	logic [CEIL_W-1:0]  ceil_reg;
	longint             prev_err;
	longint             integ_acc;

	ctl_out_t    drive_queue [$];
	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_pct   = 20;
	int unsigned stall_left  = 0;
	int unsigned idle_pct    = 25;
	row_t        dir_rows [N_DIR];

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_distance_pid_controller_unit NOT OK");
		$finish;
	end

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("%s", msg);
	endtask

	function automatic ctl_out_t pid_update(input dist_t goal, input dist_t trav, input logic rs);
		longint   kp, ki, kd, lim, cap, err, diff, mag, acc, drive;
		ctl_out_t o;
		kp  = $signed(kp_reg);
		ki  = $signed(ki_reg);
		kd  = $signed(kd_reg);
		lim = lim_reg;
		cap = ceil_reg;
		if (rs) integ_acc = 0;
		err = longint'(goal) - longint'(trav);
		if (err > cap) err = cap;
		diff = err - prev_err;
		acc = integ_acc + err;
		if (acc > lim) acc = lim;
		if (acc < -lim) acc = -lim;
		integ_acc = acc;
		mag = (err < 0) ? -err : err;
		if (diff >= mag) diff = 0;
		drive = ((kp * err) >>> FRAC_W) + ((ki * acc) >>> FRAC_W) + ((kd * diff) >>> FRAC_W);
		if (drive > DRIVE_MAX) drive = DRIVE_MAX;
		if (drive < -DRIVE_MAX) drive = -DRIVE_MAX;
		prev_err = err;
		o.drive = drive_t'(drive);
		o.diff  = diff_t'(diff);
		return o;
	endfunction

	function automatic row_t smp(input longint g, input longint t, input logic rs);
		row_t r;
		r      = '0;
		r.kind = ROW_SAMPLE;
		r.goal = dist_t'(g);
		r.trav = dist_t'(t);
		r.rst  = rs;
		return r;
	endfunction

	function automatic row_t smp_lit(input longint g, input longint t, input logic rs,
			input longint d, input longint f);
		row_t r;
		r           = smp(g, t, rs);
		r.lit       = 1'b1;
		r.lit_drive = drive_t'(d);
		r.lit_diff  = diff_t'(f);
		return r;
	endfunction

	function automatic row_t wr(input logic [2:0] idx, input logic [DATA_W-1:0] d);
		row_t r;
		r      = '0;
		r.kind = ROW_WRITE;
		r.idx  = idx;
		r.data = d;
		return r;
	endfunction

	function automatic longint srand(input longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	function automatic longint clip_dist(input longint v);
		if (v > DIST_MAX) return DIST_MAX;
		if (v < DIST_MIN) return DIST_MIN;
		return v;
	endfunction

	task automatic apb_access(input logic wr_en, input logic [2:0] idx,
			input logic [DATA_W-1:0] wd, output logic [DATA_W-1:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr_en;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] wd);
		logic [DATA_W-1:0] unused_rd;
		apb_access(1'b1, idx, wd, unused_rd);
		case (idx)
			REG_PROP_GAIN:      kp_reg   = wd[GAIN_W-1:0];
			REG_INTEG_GAIN:     ki_reg   = wd[GAIN_W-1:0];
			REG_DERIV_GAIN:     kd_reg   = wd[GAIN_W-1:0];
			REG_INTEGRAL_LIMIT: lim_reg  = wd[LIMIT_W-1:0];
			REG_ERROR_CEILING:  ceil_reg = wd[CEIL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [DATA_W-1:0] rd, want, mask;
		int unsigned       w;
		for (int k = 0; k < NUM_REGS; k++) begin
			case (k)
				REG_PROP_GAIN:      begin want = DATA_W'(kp_reg);   w = GAIN_W;  end
				REG_INTEG_GAIN:     begin want = DATA_W'(ki_reg);   w = GAIN_W;  end
				REG_DERIV_GAIN:     begin want = DATA_W'(kd_reg);   w = GAIN_W;  end
				REG_INTEGRAL_LIMIT: begin want = DATA_W'(lim_reg);  w = LIMIT_W; end
				default:            begin want = DATA_W'(ceil_reg); w = CEIL_W;  end
			endcase
			apb_access(1'b0, k[2:0], '0, rd);
			mask = {DATA_W{1'b1}} >> (DATA_W - w);
			if ((rd & mask) !== want)
				note_fail($sformatf("register %0d read: exp %h got %h", k, want, rd & mask));
		end
	endtask

	task automatic send_sample(input dist_t g, input dist_t t, input logic rs,
			input logic lit, input drive_t ld, input diff_t lf);
		ctl_out_t p;
		sample.valid             <= 1'b1;
		sample.goal_distance     <= g;
		sample.distance_traveled <= t;
		sample.restart           <= rs;
		do @(posedge clk); while (!sample.ready);
		p = pid_update(g, t, rs);
		if (lit) begin
			p.drive = ld;
			p.diff  = lf;
		end
		drive_queue.push_back(p);
	endtask

	task automatic idle_cycles(input int unsigned n);
		sample.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		sample.valid <= 1'b0;
		do @(posedge clk); while (drive_queue.size() != 0);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			result.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			result.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 2);
		end else begin
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		ctl_out_t want;
		if (arst_n && result.valid && result.ready) begin
			if (drive_queue.size() == 0) begin
				note_fail($sformatf("unexpected result: drive %0d diff %0d",
					result.drive_value, result.diff_error));
			end else begin
				want = drive_queue.pop_front();
				if (result.drive_value !== want.drive)
					note_fail($sformatf("drive_value: exp %0d got %0d",
						want.drive, result.drive_value));
				if (result.diff_error !== want.diff)
					note_fail($sformatf("diff_error: exp %0d got %0d",
						want.diff, result.diff_error));
			end
		end
	end

	initial begin : stimulus
		row_t              row;
		dist_t             g, t;
		logic              rs;
		logic [DATA_W-1:0] wd;
		longint            cur_goal, cur_trav;
		int unsigned       sel, mode;
		arst_n                   <= 1'b0;
		sample.valid             <= 1'b0;
		sample.goal_distance     <= '0;
		sample.distance_traveled <= '0;
		sample.restart           <= 1'b0;
		psel                     <= 1'b0;
		penable                  <= 1'b0;
		pwrite                   <= 1'b0;
		paddr                    <= '0;
		pwdata                   <= '0;
		kp_reg    = PROP_GAIN_RST;
		ki_reg    = INTEG_GAIN_RST;
		kd_reg    = DERIV_GAIN_RST;
		lim_reg   = INTEGRAL_LIMIT_RST;
		ceil_reg  = ERROR_CEILING_RST;
		prev_err  = 0;
		integ_acc = 0;
		cur_goal  = 0;
		cur_trav  = 0;

		dir_rows = '{
			smp_lit(0, 0, 1'b0, 0, 0),
			smp_lit(DIST_MAX, DIST_MIN, 1'b0, 65536, 0),
			smp(DIST_MIN, DIST_MAX, 1'b0),
			smp_lit(0, 0, 1'b1, 0, 0),
			wr(REG_INTEG_GAIN, 32'd65536),
			wr(REG_INTEGRAL_LIMIT, 32'd0),
			smp_lit(65536, 0, 1'b0, 26214, 0),
			smp_lit(0, 65536, 1'b0, -65536, -131072),
			wr(REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF),
			smp(131072, 0, 1'b1),
			smp(-200000, 100000, 1'b0),
			wr(REG_ERROR_CEILING, 32'd0),
			smp(65536, 0, 1'b0),
			smp(-65536, 0, 1'b0),
			wr(REG_ERROR_CEILING, 32'hFFFF_FFFF),
			smp(DIST_MAX, DIST_MIN, 1'b0),
			wr(REG_PROP_GAIN, 32'h007F_FFFF),
			wr(REG_DERIV_GAIN, 32'h0080_0000),
			wr(REG_INTEG_GAIN, 32'hFF80_0000),
			smp(1000, 0, 1'b0),
			smp(0, 0, 1'b0),
			smp(DIST_MIN, DIST_MAX, 1'b1),
			wr(IDX_UNUSED_LO, 32'h1234_5678),
			wr(IDX_UNUSED_HI, 32'hFFFF_FFFF),
			smp(-1, 0, 1'b0),
			wr(REG_PROP_GAIN, 32'd0),
			wr(REG_DERIV_GAIN, 32'd0),
			smp(262144, 3, 1'b0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_regs();

		for (int i = 0; i < N_DIR; i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_WRITE) begin
				wait_drained();
				reg_write(row.idx, row.data);
			end else begin
				if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 3));
				send_sample(row.goal, row.trav, row.rst, row.lit, row.lit_drive, row.lit_diff);
			end
		end
		wait_drained();
		check_regs();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			for (int k = 0; k < NUM_REGS; k++) begin
				wd  = $urandom();
				sel = $urandom_range(0, 5);
				case (k)
					REG_INTEGRAL_LIMIT:
						case (sel)
							0:       wd[LIMIT_W-1:0] = '0;
							1:       wd[LIMIT_W-1:0] = '1;
							2, 3:    wd[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 8 * 65536));
							default: ;
						endcase
					REG_ERROR_CEILING:
						case (sel)
							0:       wd[CEIL_W-1:0] = '0;
							1:       wd[CEIL_W-1:0] = '1;
							2:       wd[CEIL_W-1:0] = ERROR_CEILING_RST;
							3, 4:    wd[CEIL_W-1:0] = CEIL_W'($urandom_range(0, 10 * 65536));
							default: ;
						endcase
					default:
						case (sel)
							0:       wd[GAIN_W-1:0] = 24'h80_0000;
							1:       wd[GAIN_W-1:0] = 24'h7F_FFFF;
							default: wd[GAIN_W-1:0] = GAIN_W'(srand(4 * 65536));
						endcase
				endcase
				reg_write(k[2:0], wd);
			end
			check_regs();

			if (ph == NUM_PHASES - 1) begin
				idle_pct   = 0;
				stall_pct <= 0;
			end else if (ph == 0) begin
				idle_pct   = 30;
				stall_pct <= 30;
			end else begin
				case ($urandom_range(0, 2))
					0:       idle_pct = 0;
					1:       idle_pct = 10;
					default: idle_pct = 30;
				endcase
				stall_pct <= 10 * $urandom_range(0, 3);
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 199) == 0) wait_drained();
				if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 3));
				mode = $urandom_range(0, 19);
				if (mode < 2) begin
					g = dist_t'($urandom());
					t = dist_t'($urandom());
				end else begin
					if (mode < 4) begin
						if ($urandom_range(0, 3) == 0)
							cur_goal = longint'(dist_t'($urandom()));
						else
							cur_goal = clip_dist(cur_trav + srand(12 * 65536));
					end else begin
						cur_trav = clip_dist(cur_trav
							+ (cur_goal - cur_trav) / longint'($urandom_range(2, 8))
							+ srand(1024));
					end
					g = dist_t'(cur_goal);
					t = dist_t'(cur_trav);
				end
				rs = ($urandom_range(0, 19) == 0);
				send_sample(g, t, rs, 1'b0, '0, '0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && drive_queue.size() == 0) begin
			$display("tb_distance_pid_controller_unit OK");
		end else begin
			$display("tb_distance_pid_controller_unit NOT OK");
		end
		$finish;
	end

endmodule

// ----- distance_pid_controller_unit.f -----
design/dpc_pkg.sv
design/dpc_sample_if.sv
design/dpc_result_if.sv
design/distance_pid_controller_unit.sv
test/tb_distance_pid_controller_unit.sv
